>>> rtl/jeop_pkg.sv
// Shared types, constants and byte-order helpers for the EXIF orientation parser.
package jeop_pkg;

    localparam logic [7:0]  MK_FF     = 8'hFF;
    localparam logic [7:0]  MK_SOI    = 8'hD8;
    localparam logic [7:0]  MK_EOI    = 8'hD9;
    localparam logic [7:0]  MK_SOS    = 8'hDA;
    localparam logic [7:0]  MK_APP1   = 8'hE1;
    localparam logic [7:0]  MK_RST0   = 8'hD0;
    localparam logic [7:0]  MK_RST7   = 8'hD7;
    localparam logic [7:0]  MK_TEM    = 8'h01;
    localparam logic [15:0] TIFF_MAGIC = 16'h002A;
    localparam logic [15:0] TAG_ORIENT = 16'h0112;
    localparam logic [15:0] TYPE_SHORT = 16'h0003;
    localparam logic [7:0]  ORD_INTEL  = 8'h49;
    localparam logic [7:0]  ORD_MOTO   = 8'h4D;
    localparam int unsigned MIN_FILE   = 12;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0] orientation;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic [3:0] orientation;
    } t_result;

    typedef enum logic [12:0] {
        PH_SOI0  = 13'b0000000000001,
        PH_SOI1  = 13'b0000000000010,
        PH_SCAN  = 13'b0000000000100,
        PH_MARK  = 13'b0000000001000,
        PH_LENHI = 13'b0000000010000,
        PH_LENLO = 13'b0000000100000,
        PH_LHI_A = 13'b0000001000000,
        PH_LLO_A = 13'b0000010000000,
        PH_SKIP  = 13'b0000100000000,
        PH_IDENT = 13'b0001000000000,
        PH_HEAD  = 13'b0010000000000,
        PH_IFD   = 13'b0100000000000,
        PH_DONE  = 13'b1000000000000
    } t_phase;

    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0: r = 8'h45;
            3'd1: r = 8'h78;
            3'd2: r = 8'h69;
            3'd3: r = 8'h66;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] get16(input logic be, input logic [7:0] a,
                                          input logic [7:0] b);
        return be ? {a, b} : {b, a};
    endfunction

    function automatic logic [31:0] get32(input logic be, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] c,
                                          input logic [7:0] d);
        return be ? {a, b, c, d} : {d, c, b, a};
    endfunction

endpackage

>>> rtl/jeop_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface jeop_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/jeop_core.sv
// Per-byte marker scan, Exif header decode and IFD entry match.
module jeop_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  jeop_pkg::t_in_word i_word,
    output jeop_pkg::t_result  o_res
);
    import jeop_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_seen, n_seen;
    logic [7:0]  r_prev, n_prev;
    logic [15:0] r_len, n_len;
    logic [15:0] r_left, n_left;
    logic [15:0] r_tpos, n_tpos;
    logic [7:0]  r_hdr [8];
    logic [7:0]  n_hdr [8];
    logic        r_be, n_be;
    logic [15:0] r_off, n_off;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_ent [12];
    logic [7:0]  n_ent [12];
    logic [3:0]  r_k, n_k;
    logic [3:0]  r_val, n_val;
    logic [31:0] r_end, n_end;

    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] tsize;
    logic [31:0] off32;
    logic [15:0] rel;
    logic [15:0] cnt;
    logic [15:0] ov;
    logic [32:0] end_sum;
    logic        hit;
    logic [3:0]  src;

    function automatic logic hit_or_found(input logic [3:0] v, input logic [31:0] e,
                                          input logic [31:0] s, input t_phase p0,
                                          input t_phase p1);
        logic ok;
        ok = (p1 == PH_DONE) && (s >= 32'(MIN_FILE)) && (e <= s) && (v != 4'd0 || p0 != p1);
        return ok;
    endfunction

    always_comb begin
        b       = i_word.byte_value;
        n_phase = r_phase;
        n_seen  = (r_seen == '1) ? r_seen : r_seen + 32'd1;
        n_prev  = r_prev;
        n_len   = r_len;
        n_left  = r_left;
        n_tpos  = r_tpos;
        n_hdr   = r_hdr;
        n_be    = r_be;
        n_off   = r_off;
        n_cnt   = r_cnt;
        n_ent   = r_ent;
        n_k     = r_k;
        n_val   = r_val;
        n_end   = r_end;
        len     = {r_prev, b};
        tsize   = r_len - 16'd8;
        off32   = '0;
        rel     = r_tpos - r_off;
        cnt     = '0;
        ov      = '0;
        hit     = 1'b0;
        src     = '0;
        end_sum = {1'b0, r_seen} + 33'd1 + {17'd0, r_left - 16'd1};
        unique case (r_phase)
            PH_SOI0: n_phase = (b == MK_FF) ? PH_SOI1 : PH_DONE;
            PH_SOI1: n_phase = (b == MK_SOI) ? PH_SCAN : PH_DONE;
            PH_SCAN: if (b == MK_FF) begin
                n_phase = PH_MARK;
            end
            PH_MARK: begin
                if (b == MK_FF) begin
                    n_phase = PH_MARK;
                end else if (b == MK_EOI || b == MK_SOS) begin
                    n_phase = PH_DONE;
                end else if ((b >= MK_RST0 && b <= MK_RST7) || b == MK_SOI || b == MK_TEM) begin
                    n_phase = PH_SCAN;
                end else begin
                    n_phase = (b == MK_APP1) ? PH_LHI_A : PH_LENHI;
                end
            end
            PH_LENHI, PH_LHI_A: begin
                n_prev  = b;
                n_phase = (r_phase == PH_LHI_A) ? PH_LLO_A : PH_LENLO;
            end
            PH_LENLO, PH_LLO_A: begin
                n_len = len;
                if (len < 16'd2) begin
                    n_phase = PH_DONE;
                end else begin
                    n_left = len - 16'd2;
                    if (n_left == 16'd0) begin
                        n_phase = PH_SCAN;
                    end else if (r_phase == PH_LLO_A && n_left >= 16'd14) begin
                        n_phase = PH_IDENT;
                        n_tpos  = '0;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP, PH_IDENT, PH_HEAD, PH_IFD: begin
                n_left = r_left - 16'd1;
                if (r_phase == PH_IDENT) begin
                    if (r_tpos >= 16'd6 || b != ident_byte(r_tpos[2:0])) begin
                        n_phase = PH_SKIP;
                    end else if (r_tpos == 16'd5) begin
                        n_phase = PH_HEAD;
                        n_tpos  = '0;
                    end else begin
                        n_tpos = r_tpos + 16'd1;
                    end
                end else if (r_phase == PH_HEAD) begin
                    n_hdr[r_tpos[2:0]] = b;
                    n_tpos = r_tpos + 16'd1;
                    if (r_tpos >= 16'd7) begin
                        if (n_hdr[0] == ORD_INTEL && n_hdr[1] == ORD_INTEL) begin
                            n_be = 1'b0;
                        end else if (n_hdr[0] == ORD_MOTO && n_hdr[1] == ORD_MOTO) begin
                            n_be = 1'b1;
                        end
                        off32 = get32(n_be, n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]);
                        if (!((n_hdr[0] == ORD_INTEL && n_hdr[1] == ORD_INTEL) ||
                              (n_hdr[0] == ORD_MOTO && n_hdr[1] == ORD_MOTO))) begin
                            n_phase = PH_SKIP;
                        end else if (get16(n_be, n_hdr[2], n_hdr[3]) != TIFF_MAGIC) begin
                            n_phase = PH_SKIP;
                        end else if (off32 > {16'd0, tsize} ||
                                     (tsize - off32[15:0]) < 16'd2) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_off   = off32[15:0];
                            n_phase = PH_IFD;
                            n_tpos  = 16'd8;
                            n_k     = (off32[15:0] < 16'd6) ? 4'(16'd6 - off32[15:0]) : 4'd0;
                            if (off32[15:0] < 16'd8) begin
                                n_ent[0] = n_hdr[off32[2:0]];
                            end
                            if (off32[15:0] <= 16'd6) begin
                                n_ent[1] = n_hdr[3'(off32[2:0] + 3'd1)];
                                cnt      = get16(n_be, n_ent[0], n_ent[1]);
                                n_cnt    = cnt;
                                if (cnt == 16'd0) begin
                                    n_phase = PH_SKIP;
                                end
                            end
                            for (int j = 0; j < 6; j++) begin
                                src = 4'(off32[3:0] + 4'(j + 2));
                                if (off32[15:0] < 16'd6 && src < 4'd8) begin
                                    n_ent[j] = n_hdr[src[2:0]];
                                end
                            end
                        end
                    end
                end else if (r_phase == PH_IFD) begin
                    n_tpos = r_tpos + 16'd1;
                    if (r_tpos >= r_off) begin
                        if (rel == 16'd0) begin
                            n_ent[0] = b;
                        end else if (rel == 16'd1) begin
                            cnt   = get16(r_be, r_ent[0], b);
                            n_cnt = cnt;
                            if (cnt == 16'd0) begin
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            n_ent[r_k] = b;
                            n_k = (r_k == 4'd11) ? 4'd0 : r_k + 4'd1;
                            if (r_k == 4'd11) begin
                                hit = get16(r_be, r_ent[0], r_ent[1]) == TAG_ORIENT &&
                                      get16(r_be, r_ent[2], r_ent[3]) == TYPE_SHORT &&
                                      get32(r_be, r_ent[4], r_ent[5], r_ent[6], r_ent[7])
                                          == 32'd1;
                                ov  = get16(r_be, r_ent[8], r_ent[9]);
                                if (hit) begin
                                    n_val   = (ov >= 16'd1 && ov <= 16'd8) ? ov[3:0] : 4'd0;
                                    n_end   = end_sum[32] ? '1 : end_sum[31:0];
                                    n_phase = PH_DONE;
                                end else begin
                                    n_cnt = r_cnt - 16'd1;
                                    if (n_cnt == 16'd0) begin
                                        n_phase = PH_SKIP;
                                    end
                                end
                            end
                        end
                    end
                end
                if (n_left == 16'd0 && (n_phase == PH_SKIP || n_phase == PH_IDENT ||
                                        n_phase == PH_HEAD || n_phase == PH_IFD)) begin
                    n_phase = PH_SCAN;
                end
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
        o_res.valid       = i_word.last_byte;
        o_res.orientation = (n_phase == PH_DONE && hit_or_found(n_val, n_end, n_seen, r_phase,
                                                               n_phase))
                            ? n_val : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOI0;
            r_seen  <= '0;
            r_prev  <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_tpos  <= '0;
            r_be    <= 1'b0;
            r_off   <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_val   <= '0;
            r_end   <= '0;
        end else if (i_en) begin
            if (i_word.last_byte) begin
                r_phase <= PH_SOI0;
                r_seen  <= '0;
                r_prev  <= '0;
                r_len   <= '0;
                r_left  <= '0;
                r_tpos  <= '0;
                r_be    <= 1'b0;
                r_off   <= '0;
                r_cnt   <= '0;
                r_k     <= '0;
                r_val   <= '0;
                r_end   <= '0;
            end else begin
                r_phase <= n_phase;
                r_seen  <= n_seen;
                r_prev  <= n_prev;
                r_len   <= n_len;
                r_left  <= n_left;
                r_tpos  <= n_tpos;
                r_be    <= n_be;
                r_off   <= n_off;
                r_cnt   <= n_cnt;
                r_k     <= n_k;
                r_val   <= n_val;
                r_end   <= n_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hdr <= n_hdr;
            r_ent <= n_ent;
        end
    end

endmodule

>>> rtl/jeop_out.sv
// Result register between the parser and the output channel.
module jeop_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  jeop_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [3:0]        o_orientation,
    output logic              o_free
);
    import jeop_pkg::*;

    logic       r_vld;
    logic [3:0] r_orient;

    assign o_free        = !r_vld || i_ready;
    assign o_valid       = r_vld;
    assign o_orientation = r_orient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_en && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_en && i_res.valid) begin
            r_orient <= i_res.orientation;
        end
    end

endmodule

>>> rtl/jpeg_exif_orientation_parser_top.sv
// Top level of the JPEG EXIF orientation parser.
// The result appears in the cycle after the final byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// The result register decouples input and output.
// Reset (synchronous, active low) clears the scan state and the result valid.
module jpeg_exif_orientation_parser_top (
    input logic i_clk,
    input logic i_rst_n,
    jeop_if.sink   i_in,
    jeop_if.source o_out
);
    import jeop_pkg::*;

    t_result res;
    logic    free;
    logic    acc;
    logic [3:0] orient;

    assign i_in.ready = free;
    assign acc        = i_in.valid && free;
    assign o_out.data.orientation = orient;

    jeop_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (acc),
        .i_word  (i_in.data),
        .o_res   (res)
    );

    jeop_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (acc),
        .i_res         (res),
        .i_ready       (o_out.ready),
        .o_valid       (o_out.valid),
        .o_orientation (orient),
        .o_free        (free)
    );

endmodule

>>> rtl/jeop_chk.sv
// Port-level checker for the parser top, bound into it.
module jeop_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_orient
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("result dropped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_orient <= 4'd8) else $error("orientation out of range");
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && i_in_valid && i_in_ready && !i_last |=> !i_out_valid)
        else $error("result without final byte");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready) else $error("input stalled while empty");
endmodule

bind jpeg_exif_orientation_parser_top jeop_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_last      (i_in.data.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_orient    (o_out.data.orientation)
);

>>> tb/jpeg_exif_orientation_parser_top_tb.sv
// Testbench for the JPEG EXIF orientation parser: directed and random JPEG streams checked against a predictor.
module jpeg_exif_orientation_parser_top_tb;
    import jeop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        S_SOI0, S_SOI1, S_SCAN, S_MARK, S_LENHI, S_LENLO, S_LENHI_A, S_LENLO_A,
        S_SKIP, S_IDENT, S_HEAD, S_IFD, S_DONE, S_HALT
    } t_scan_state;

    class orientation_scoreboard;
        t_scan_state phase;
        logic [31:0] nbytes;
        logic [7:0]  prev;
        logic [15:0] seglen;
        logic [15:0] seg_left;
        logic [15:0] tpos;
        logic [7:0]  hdr [8];
        logic        be;
        logic [31:0] dir_off;
        logic [15:0] n_entries;
        logic [7:0]  ent [12];
        logic [3:0]  found;
        logic [31:0] found_end;
        logic [3:0]  pending [$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase = S_SOI0;
            nbytes = 0;
            prev = 0;
            seglen = 0;
            seg_left = 0;
            tpos = 0;
            be = 0;
            dir_off = 0;
            n_entries = 0;
            found = 0;
            found_end = 0;
            foreach (hdr[i]) hdr[i] = 0;
            foreach (ent[i]) ent[i] = 0;
        endfunction

        function logic [15:0] rd16(logic [7:0] a, logic [7:0] b);
            return be ? {a, b} : {b, a};
        endfunction

        function logic [31:0] rd32(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                   logic [7:0] d);
            return be ? {a, b, c, d} : {d, c, b, a};
        endfunction

        function void dir_byte(logic [7:0] b, logic [31:0] pos, logic [31:0] idx);
            logic [31:0] rel;
            logic [31:0] k;
            logic [15:0] v;
            logic [32:0] e;
            if (pos < dir_off) return;
            rel = pos - dir_off;
            if (rel < 2) begin
                ent[rel] = b;
                if (rel == 1) begin
                    n_entries = rd16(ent[0], ent[1]);
                    if (n_entries == 0) phase = S_SKIP;
                end
                return;
            end
            k = (rel - 2) % 12;
            ent[k] = b;
            if (k != 11) return;
            if (rd16(ent[0], ent[1]) == TAG_ORIENT && rd16(ent[2], ent[3]) == TYPE_SHORT &&
                rd32(ent[4], ent[5], ent[6], ent[7]) == 1) begin
                v = rd16(ent[8], ent[9]);
                found = (v >= 1 && v <= 8) ? v[3:0] : 4'd0;
                e = {1'b0, idx} + 33'd1 + seg_left;
                found_end = e[32] ? 32'hFFFF_FFFF : e[31:0];
                phase = S_DONE;
                return;
            end
            n_entries--;
            if (n_entries == 0) phase = S_SKIP;
        endfunction

        function void close_header(logic [31:0] idx);
            logic [31:0] off;
            logic [31:0] tsize;
            if (hdr[0] == ORD_INTEL && hdr[1] == ORD_INTEL) be = 0;
            else if (hdr[0] == ORD_MOTO && hdr[1] == ORD_MOTO) be = 1;
            else begin
                phase = S_SKIP;
                return;
            end
            if (rd16(hdr[2], hdr[3]) != TIFF_MAGIC) begin
                phase = S_SKIP;
                return;
            end
            off = rd32(hdr[4], hdr[5], hdr[6], hdr[7]);
            tsize = {16'd0, seglen} - 32'd8;
            if (off > tsize || tsize - off < 2) begin
                phase = S_SKIP;
                return;
            end
            dir_off = off;
            phase = S_IFD;
            tpos = 8;
            for (int p = off; p < 8 && phase == S_IFD; p++) dir_byte(hdr[p], p, idx);
        endfunction

        function void note_byte(t_in_word w);
            logic [7:0]  b;
            logic [31:0] idx;
            logic [15:0] len;
            b = w.byte_value;
            idx = nbytes;
            if (nbytes != 32'hFFFF_FFFF) nbytes++;
            case (phase)
                S_SOI0: phase = (b == MK_FF) ? S_SOI1 : S_HALT;
                S_SOI1: phase = (b == MK_SOI) ? S_SCAN : S_HALT;
                S_SCAN: if (b == MK_FF) phase = S_MARK;
                S_MARK: begin
                    if (b == MK_FF) ;
                    else if (b == MK_EOI || b == MK_SOS) phase = S_HALT;
                    else if ((b >= MK_RST0 && b <= MK_RST7) || b == MK_SOI || b == MK_TEM)
                        phase = S_SCAN;
                    else phase = (b == MK_APP1) ? S_LENHI_A : S_LENHI;
                end
                S_LENHI, S_LENHI_A: begin
                    prev = b;
                    phase = (phase == S_LENHI) ? S_LENLO : S_LENLO_A;
                end
                S_LENLO, S_LENLO_A: begin
                    len = {prev, b};
                    seglen = len;
                    if (len < 2) phase = S_HALT;
                    else begin
                        seg_left = len - 2;
                        if (seg_left == 0) phase = S_SCAN;
                        else if (phase == S_LENLO_A && seg_left >= 14) begin
                            phase = S_IDENT;
                            tpos = 0;
                        end else phase = S_SKIP;
                    end
                end
                S_SKIP, S_IDENT, S_HEAD, S_IFD: begin
                    seg_left--;
                    if (phase == S_IDENT) begin
                        if (tpos >= 6 || b != ident_byte(tpos[2:0])) phase = S_SKIP;
                        else begin
                            tpos++;
                            if (tpos == 6) begin
                                phase = S_HEAD;
                                tpos = 0;
                            end
                        end
                    end else if (phase == S_HEAD) begin
                        hdr[tpos[2:0]] = b;
                        tpos++;
                        if (tpos >= 8) close_header(idx);
                    end else if (phase == S_IFD) begin
                        dir_byte(b, tpos, idx);
                        tpos++;
                    end
                    if (seg_left == 0 && phase inside {S_SKIP, S_IDENT, S_HEAD, S_IFD})
                        phase = S_SCAN;
                end
                S_DONE: ;
                default: phase = S_HALT;
            endcase
            if (w.last_byte) begin
                if (phase == S_DONE && nbytes >= MIN_FILE && found_end <= nbytes)
                    pending.push_back(found);
                else pending.push_back(4'd0);
                clear();
            end
        endfunction

        task check_result(t_out_word r);
            logic [3:0] exp_o;
            if (pending.size() == 0) begin
                report_err("result with nothing pending");
                return;
            end
            exp_o = pending.pop_front();
            if (r.orientation !== exp_o)
                report_err($sformatf("orientation %0d, want %0d", r.orientation, exp_o));
        endtask

        task report_err(string s);
            $display("mismatch at %0t: %s", $realtime, s);
            errors++;
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    jeop_if #(.T_DATA(t_in_word))  in_ch();
    jeop_if #(.T_DATA(t_out_word)) out_ch();

    orientation_scoreboard sb = new();
    logic [7:0] file_q [$];
    bit         stim_done = 0;
    bit         hold_off = 0;
    int         files_sent = 0;
    int         bytes_sent = 0;

    jpeg_exif_orientation_parser_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data);
        if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    task automatic send_file();
        int gap;
        for (int i = 0; i < file_q.size(); i++) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 1)) gap = 0;
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid <= 1;
            in_ch.data <= '{byte_value: file_q[i], last_byte: i == file_q.size() - 1};
            do @(posedge i_clk); while (!in_ch.ready);
            bytes_sent++;
        end
        files_sent++;
    endtask

    task automatic push16(logic [15:0] v, bit big);
        if (big) begin
            file_q.push_back(v[15:8]);
            file_q.push_back(v[7:0]);
        end else begin
            file_q.push_back(v[7:0]);
            file_q.push_back(v[15:8]);
        end
    endtask

    task automatic push32(logic [31:0] v, bit big);
        if (big) begin
            push16(v[31:16], 1);
            push16(v[15:0], 1);
        end else begin
            push16(v[15:0], 0);
            push16(v[31:16], 0);
        end
    endtask

    // Build an Exif APP1 segment; mode picks a corruption (0 for none).
    task automatic push_exif(bit big, int n_ent, int orient_at, logic [15:0] val, int mode,
                             int off);
        logic [7:0] body [$];
        logic [7:0] save [$];
        int tag_len;
        save = file_q;
        file_q = {};
        file_q.push_back(mode == 1 ? 8'h46 : 8'h45);
        file_q.push_back(8'h78);
        file_q.push_back(8'h69);
        file_q.push_back(8'h66);
        file_q.push_back(8'h00);
        file_q.push_back(8'h00);
        if (mode == 2) begin
            file_q.push_back(8'h49);
            file_q.push_back(8'h4D);
        end else begin
            file_q.push_back(big ? ORD_MOTO : ORD_INTEL);
            file_q.push_back(big ? ORD_MOTO : ORD_INTEL);
        end
        push16(mode == 3 ? 16'h002B : TIFF_MAGIC, big);
        push32(off, big);
        while (file_q.size() < 6 + off) file_q.push_back($urandom_range(0, 255));
        push16(n_ent, big);
        for (int e = 0; e < n_ent; e++) begin
            if (e == orient_at) begin
                push16(TAG_ORIENT, big);
                push16(mode == 4 ? 16'd4 : TYPE_SHORT, big);
                push32(mode == 5 ? 32'd2 : 32'd1, big);
                push16(val, big);
                push16($urandom_range(0, 65535), big);
            end else begin
                push16($urandom_range(0, 3) == 0 ? TAG_ORIENT : $urandom_range(0, 65535),
                       big);
                push16($urandom_range(1, 4), big);
                push32($urandom_range(0, 2), big);
                push32($urandom, big);
            end
        end
        repeat ($urandom_range(0, 3)) file_q.push_back($urandom_range(0, 255));
        body = file_q;
        file_q = save;
        tag_len = body.size() + 2;
        file_q.push_back(MK_FF);
        file_q.push_back(MK_APP1);
        file_q.push_back(tag_len >> 8);
        file_q.push_back(tag_len & 8'hFF);
        foreach (body[i]) file_q.push_back(body[i]);
    endtask

    task automatic push_other_segment();
        int n;
        n = $urandom_range(0, 6);
        file_q.push_back(MK_FF);
        if ($urandom_range(0, 3) == 0) file_q.push_back(MK_FF);
        file_q.push_back($urandom_range(0, 1) ? 8'hE0 : $urandom_range(0, 255));
        file_q.push_back(8'h00);
        file_q.push_back(n + 2);
        repeat (n) file_q.push_back($urandom_range(0, 255));
    endtask

    task automatic build_random_file();
        int kind;
        file_q = {};
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            repeat ($urandom_range(1, 20)) file_q.push_back($urandom_range(0, 255));
            return;
        end
        file_q.push_back(MK_FF);
        file_q.push_back(MK_SOI);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: begin
                    file_q.push_back(MK_FF);
                    file_q.push_back($urandom_range(MK_RST0, MK_RST7));
                end
                1: begin
                    file_q.push_back(MK_FF);
                    file_q.push_back(MK_TEM);
                end
                2: file_q.push_back($urandom_range(0, 254));
                default: push_other_segment();
            endcase
        end
        if (kind != 1)
            push_exif($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 9),
                      $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0,
                      $urandom_range(0, 4) == 0 ? $urandom_range(0, 12) : 8);
        if ($urandom_range(0, 1)) begin
            file_q.push_back(MK_FF);
            file_q.push_back($urandom_range(0, 1) ? MK_EOI : MK_SOS);
        end
        repeat ($urandom_range(0, 3)) file_q.push_back($urandom_range(0, 255));
        // truncate sometimes so the segment runs past the end
        if ($urandom_range(0, 5) == 0) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        // directed cases
        file_q = {8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_file();
        file_q = {8'h00, 8'hFF, 8'h00, 8'hFF};
        send_file();
        file_q = {8'hFF};
        send_file();
        for (int m = 0; m <= 5; m++) begin
            file_q = {MK_FF, MK_SOI, MK_FF, MK_FF, MK_FF, 8'h00, 8'h00, 8'h02};
            push_exif(m[0], 2, 1, 6, m, 8);
            send_file();
        end
        file_q = {MK_FF, MK_SOI};
        push_exif(1, 1, 0, 8, 0, 2);
        send_file();
        file_q = {MK_FF, MK_SOI};
        push_exif(0, 1, 0, 1, 0, 0);
        send_file();
        file_q = {MK_FF, MK_SOI, MK_FF, MK_APP1, 8'h00, 8'h01, 8'hFF};
        send_file();
        file_q = {MK_FF, MK_SOI, MK_FF, MK_APP1, 8'hFF, 8'hFF, 8'h45, 8'h78, 8'h69, 8'h66,
                  8'h00, 8'h00, 8'h4D, 8'h4D, 8'h00, 8'h2A, 8'hFF, 8'hFF};
        send_file();
        while (bytes_sent < 1150) begin
            build_random_file();
            send_file();
        end
        in_ch.valid <= 0;
        stim_done = 1;
    end

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (hold_off) begin
                @(posedge i_clk);
                out_ch.ready <= 0;
            end else begin
                repeat (gap) begin
                    @(posedge i_clk);
                    out_ch.ready <= 0;
                end
                @(posedge i_clk);
                out_ch.ready <= 1;
            end
        end
    end

    initial begin
        wait (files_sent == 3);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("jpeg_exif_orientation_parser_top_tb: PASS");
        else $display("jpeg_exif_orientation_parser_top_tb: FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("jpeg_exif_orientation_parser_top_tb: FAIL");
        $finish;
    end
endmodule
